// ===== hw/rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, register indexes and helpers for the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int DW = 32;

  localparam logic [31:0] C_T_OFFS   = 32'd4000;
  localparam logic [31:0] C_B7_SCALE = 32'd50000;
  localparam logic [31:0] C_B4_OFFS  = 32'd32768;
  localparam logic [31:0] C_P_SQ     = 32'd3038;
  localparam logic [31:0] C_P_LIN    = 32'd7357;
  localparam logic [31:0] C_P_OFFS   = 32'd3791;

  typedef enum logic [2:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4,
    CFG_OSS     = 3'd5
  } bsc_cfg_idx_t;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [23:0] raw_press;
  } bsc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_tenths;
    logic signed [31:0] press_pa;
    logic               divide_fault;
  } bsc_out_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // low 32 bits of a product; identical for signed and unsigned operands
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

endpackage

// ===== hw/rtl/bsc_udiv.sv =====
// ----------------------------------------------------------------------------
// bsc_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// side-band data carried alongside.
// ----------------------------------------------------------------------------
module bsc_udiv #(
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [bsc_pkg::DW-1:0] dividend,
  input  logic [bsc_pkg::DW-1:0] divisor,
  input  logic [PW-1:0]        pass_in,
  output logic                 out_vld,
  output logic [bsc_pkg::DW-1:0] quot,
  output logic [PW-1:0]        pass_out
);
  import bsc_pkg::*;

  logic [DW-1:0] rem_r  [1:DW];
  logic [DW-1:0] dq_r   [1:DW];
  logic [DW-1:0] dvs_r  [1:DW];
  logic [PW-1:0] pass_r [1:DW];
  logic          vld_r  [1:DW];

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic [DW-1:0] rem_p, dq_p, dvs_p;
    logic [PW-1:0] pass_p;
    logic          vld_p;
    logic [DW:0]   sh, df;

    if (k == 1) begin : g_first
      assign rem_p  = '0;
      assign dq_p   = dividend;
      assign dvs_p  = divisor;
      assign pass_p = pass_in;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign dq_p   = dq_r[k-1];
      assign dvs_p  = dvs_r[k-1];
      assign pass_p = pass_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    assign sh = {rem_p, dq_p[DW-1]};
    assign df = sh - {1'b0, dvs_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= df[DW] ? sh[DW-1:0] : df[DW-1:0];
        dq_r[k]   <= {dq_p[DW-2:0], ~df[DW]};
        dvs_r[k]  <= dvs_p;
        pass_r[k] <= pass_p;
      end
    end
  end

  assign out_vld  = vld_r[DW];
  assign quot     = dq_r[DW];
  assign pass_out = pass_r[DW];

endmodule

// ===== hw/rtl/barometric_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
//  channel | ports                          | transfer when
//  in      | in_valid, in_stall, in_data    | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data | out_valid && !out_stall
//  cfg     | cfg_we, cfg_idx, cfg_data      | cfg_we
//
//  One reading per cycle unless stalled; 14 arithmetic stages, two 32-stage
//  bit-per-cycle dividers and an output register. The dividers set depth.
//  Reset (rst_n low, synchronous) clears all valid bits and the config registers.
//  The whole pipe holds while a result sits in the output register stalled.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bsc_pkg::bsc_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output bsc_pkg::bsc_out_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [31:0]      cfg_data
);
  import bsc_pkg::*;

  localparam int PW1 = 32 + 24 + 2;
  localparam int PW2 = 32 + 2;

  logic [31:0] ac1_ac2_r, ac3_ac4_r, ac5_ac6_r, b1_b2_r, mc_md_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_ac2_r <= '0;
      ac3_ac4_r <= '0;
      ac5_ac6_r <= '0;
      b1_b2_r   <= '0;
      mc_md_r   <= '0;
      oss_r     <= '0;
    end else if (cfg_we) begin
      case (bsc_cfg_idx_t'(cfg_idx))
        CFG_AC1_AC2: ac1_ac2_r <= cfg_data;
        CFG_AC3_AC4: ac3_ac4_r <= cfg_data;
        CFG_AC5_AC6: ac5_ac6_r <= cfg_data;
        CFG_B1_B2:   b1_b2_r   <= cfg_data;
        CFG_MC_MD:   mc_md_r   <= cfg_data;
        CFG_OSS:     oss_r     <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(ac1_ac2_r[31:16]);
  assign ac2 = sx16(ac1_ac2_r[15:0]);
  assign ac3 = sx16(ac3_ac4_r[31:16]);
  assign ac4 = {16'b0, ac3_ac4_r[15:0]};
  assign ac5 = {16'b0, ac5_ac6_r[31:16]};
  assign ac6 = {16'b0, ac5_ac6_r[15:0]};
  assign b1  = sx16(b1_b2_r[31:16]);
  assign b2  = sx16(b1_b2_r[15:0]);
  assign mc  = sx16(mc_md_r[31:16]);
  assign md  = sx16(mc_md_r[15:0]);

  logic adv;
  logic out_valid_r;
  bsc_out_t out_data_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;
  logic v12_r, v13_r, v14_r;
  logic d1_vld, d2_vld;

  // stage payloads
  logic [31:0] s1_d_r;
  logic [23:0] s1_up_r, s2_up_r, s3_up_r, s4_up_r, s5_up_r, s6_up_r, s7_up_r;
  logic [23:0] s8_up_r;
  logic [31:0] s2_x1_r, s3_x1_r, s4_b5_r, s5_b6_r;
  logic [31:0] s3_dvd_r, s3_dvs_r;
  logic        s3_neg_r, s3_fz_r;
  logic [31:0] s5_t_r, s6_t_r, s7_t_r, s8_t_r, s9_t_r, s10_t_r, s11_t_r;
  logic [31:0] s12_t_r, s13_t_r, s14_t_r;
  logic        s4_fz_r, s5_fz_r, s6_fz_r, s7_fz_r, s8_fz_r, s9_fz_r, s10_fz_r;
  logic        s11_fz_r, s12_fz_r, s13_fz_r, s14_fz_r;
  logic [31:0] s6_sqp_r, s6_a2p_r, s6_a3p_r;
  logic [31:0] s7_b2sq_r, s7_b1sq_r, s7_x2a_r, s7_x1c_r;
  logic [31:0] s8_b3_r, s8_x3b_r;
  logic [31:0] s9_b4_r, s9_diff_r;
  logic [31:0] s10_b7_r, s10_b4_r;
  logic [31:0] s11_dvd_r, s11_dvs_r;
  logic        s11_dbl_r;
  logic [31:0] s12_p_r, s13_p_r, s14_p_r;
  logic [31:0] s13_pp_r, s13_m_r, s14_pp3_r, s14_x2_r;

  // divider 1 results
  logic [31:0]    q1;
  logic [PW1-1:0] p1_out;
  logic [31:0]    d1_x1;
  logic [23:0]    d1_up;
  logic           d1_neg, d1_fz;
  assign {d1_x1, d1_up, d1_neg, d1_fz} = p1_out;

  // divider 2 results
  logic [31:0]    q2;
  logic [PW2-1:0] p2_out;
  logic [31:0]    d2_t;
  logic           d2_dbl, d2_fz;
  assign {d2_t, d2_dbl, d2_fz} = p2_out;

  // combinational stage logic
  logic [31:0] s3_den, s3_num;
  logic [31:0] s4_x2;
  logic [31:0] s7_sq;
  logic [31:0] s8_x3, s8_v, s8_vb;
  logic [31:0] s13_p8;
  logic [31:0] s15_p;

  assign s3_den = s2_x1_r + md;
  assign s3_num = mc << 11;
  assign s4_x2  = d1_neg ? (32'd0 - q1) : q1;
  assign s7_sq  = asr32(s6_sqp_r, 5'd12);
  assign s8_x3  = asr32(s7_b2sq_r, 5'd11) + s7_x2a_r;
  assign s8_v   = (((ac1 << 2) + s8_x3) << oss_r) + 32'd2;
  assign s8_vb  = s8_v + (s8_v[31] ? 32'd3 : 32'd0);
  assign s13_p8 = asr32(s12_p_r, 5'd8);
  assign s15_p  = s14_p_r + asr32(asr32(s14_pp3_r, 5'd16) + s14_x2_r + C_P_OFFS, 5'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0; v2_r  <= 1'b0; v3_r  <= 1'b0; v4_r  <= 1'b0;
      v5_r  <= 1'b0; v6_r  <= 1'b0; v7_r  <= 1'b0; v8_r  <= 1'b0;
      v9_r  <= 1'b0; v10_r <= 1'b0; v11_r <= 1'b0; v12_r <= 1'b0;
      v13_r <= 1'b0; v14_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= d1_vld;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= d2_vld;
      v13_r <= v12_r;
      v14_r <= v13_r;
      out_valid_r <= v14_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // raw temperature offset, pressure aligned to the oversampling setting
      s1_d_r  <= {16'b0, in_data.raw_temp} - ac6;
      s1_up_r <= in_data.raw_press >> (4'd8 - {2'b0, oss_r});

      s2_x1_r <= asr32(mul32(s1_d_r, ac5), 5'd15);
      s2_up_r <= s1_up_r;

      // signed division on magnitudes, sign fixed after the divider
      s3_dvd_r <= s3_num[31] ? (32'd0 - s3_num) : s3_num;
      s3_dvs_r <= s3_den[31] ? (32'd0 - s3_den) : s3_den;
      s3_neg_r <= s3_num[31] ^ s3_den[31];
      s3_fz_r  <= (s3_den == 32'd0);
      s3_x1_r  <= s2_x1_r;
      s3_up_r  <= s2_up_r;

      s4_b5_r <= d1_x1 + s4_x2;
      s4_up_r <= d1_up;
      s4_fz_r <= d1_fz;

      s5_t_r  <= asr32(s4_b5_r + 32'd8, 5'd4);
      s5_b6_r <= s4_b5_r - C_T_OFFS;
      s5_up_r <= s4_up_r;
      s5_fz_r <= s4_fz_r;

      s6_sqp_r <= mul32(s5_b6_r, s5_b6_r);
      s6_a2p_r <= mul32(ac2, s5_b6_r);
      s6_a3p_r <= mul32(ac3, s5_b6_r);
      s6_t_r   <= s5_t_r;
      s6_up_r  <= s5_up_r;
      s6_fz_r  <= s5_fz_r;

      s7_b2sq_r <= mul32(b2, s7_sq);
      s7_b1sq_r <= mul32(b1, s7_sq);
      s7_x2a_r  <= asr32(s6_a2p_r, 5'd11);
      s7_x1c_r  <= asr32(s6_a3p_r, 5'd13);
      s7_t_r    <= s6_t_r;
      s7_up_r   <= s6_up_r;
      s7_fz_r   <= s6_fz_r;

      // truncating divide by four: bias negatives before the shift
      s8_b3_r  <= asr32(s8_vb, 5'd2);
      s8_x3b_r <= asr32(s7_x1c_r + asr32(s7_b1sq_r, 5'd16) + 32'd2, 5'd2);
      s8_t_r   <= s7_t_r;
      s8_up_r  <= s7_up_r;
      s8_fz_r  <= s7_fz_r;

      s9_b4_r   <= mul32(ac4, s8_x3b_r + C_B4_OFFS) >> 15;
      s9_diff_r <= {8'b0, s8_up_r} - s8_b3_r;
      s9_t_r    <= s8_t_r;
      s9_fz_r   <= s8_fz_r;

      s10_b7_r <= mul32(s9_diff_r, C_B7_SCALE >> oss_r);
      s10_b4_r <= s9_b4_r;
      s10_t_r  <= s9_t_r;
      s10_fz_r <= s9_fz_r | (s9_b4_r == 32'd0);

      // double before dividing when the top bit is clear, else after
      s11_dvd_r <= s10_b7_r[31] ? s10_b7_r : (s10_b7_r << 1);
      s11_dvs_r <= s10_b4_r;
      s11_dbl_r <= s10_b7_r[31];
      s11_t_r   <= s10_t_r;
      s11_fz_r  <= s10_fz_r;

      s12_p_r  <= d2_dbl ? (q2 << 1) : q2;
      s12_t_r  <= d2_t;
      s12_fz_r <= d2_fz;

      s13_pp_r <= mul32(s13_p8, s13_p8);
      s13_m_r  <= mul32(C_P_LIN, s12_p_r);
      s13_p_r  <= s12_p_r;
      s13_t_r  <= s12_t_r;
      s13_fz_r <= s12_fz_r;

      s14_pp3_r <= mul32(s13_pp_r, C_P_SQ);
      s14_x2_r  <= asr32(32'd0 - s13_m_r, 5'd16);
      s14_p_r   <= s13_p_r;
      s14_t_r   <= s13_t_r;
      s14_fz_r  <= s13_fz_r;

      out_data_r.temp_tenths  <= s14_fz_r ? 32'sd0 : $signed(s14_t_r);
      out_data_r.press_pa     <= s14_fz_r ? 32'sd0 : $signed(s15_p);
      out_data_r.divide_fault <= s14_fz_r;
    end
  end

  bsc_udiv #(.PW(PW1)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v3_r),
    .dividend (s3_dvd_r),
    .divisor  (s3_dvs_r),
    .pass_in  ({s3_x1_r, s3_up_r, s3_neg_r, s3_fz_r}),
    .out_vld  (d1_vld),
    .quot     (q1),
    .pass_out (p1_out)
  );

  bsc_udiv #(.PW(PW2)) u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (v11_r),
    .dividend (s11_dvd_r),
    .divisor  (s11_dvs_r),
    .pass_in  ({s11_t_r, s11_dbl_r, s11_fz_r}),
    .out_vld  (d2_vld),
    .quot     (q2),
    .pass_out (p2_out)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/bsc_check.sv =====
// ----------------------------------------------------------------------------
// bsc_check
// Port-level checks on the barometric compensation block.
// ----------------------------------------------------------------------------
module bsc_check (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input bsc_pkg::bsc_out_t out_data
);
  import bsc_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_fault |->
      out_data.temp_tenths == 32'sd0 && out_data.press_pa == 32'sd0)
    else $error("fault result not zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind barometric_sensor_compensation bsc_check u_chk (.*);
